// ===== rtl/sector_cache_clock_replacement_unit_defines.svh =====
// ============================================================================
// Sector cache clock replacement unit: assertion macros
// Shorthand for the clocked, reset-qualified properties of the port checker.
// ============================================================================
`ifndef SECTOR_CACHE_CLOCK_REPLACEMENT_UNIT_DEFINES_SVH
`define SECTOR_CACHE_CLOCK_REPLACEMENT_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCCR_ASSERT_SAME(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCCR_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sccr_pkg.sv =====
// ============================================================================
// sccr_pkg
// Shared sizes and controller/datapath interface types of the sector cache
// clock replacement unit.
// ============================================================================
package sccr_pkg;

    // Number of cache entries and the width of an entry index.
    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Field widths.
    localparam int SECTOR_W = 32;
    localparam int ENTRY_W  = 6;

    // Stream widths: result fields packed from bit 0, padded to whole bytes.
    localparam int S_TDATA_W = SECTOR_W;
    localparam int OUT_BITS  = 1 + ENTRY_W + 1 + 1 + SECTOR_W;
    localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the accepted transaction
        logic cmp;        // compare the sector against every valid tag
        logic look;       // pick the hit entry or the lowest free entry
        logic scan_step;  // examine the entry under the clock hand
        logic commit;     // load the result and update the entry state
    } sccr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit_found;
        logic free_found;
        logic ref_at_hand;
    } sccr_status_t;

endpackage

// ===== rtl/sccr_datapath.sv =====
// ============================================================================
// sccr_datapath
// Tag match array, per-entry valid/dirty/reference bits, clock hand, victim
// tag memory and result register of the sector cache.
// ============================================================================
module sccr_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sccr_pkg::sccr_cmd_t             cmd,
    output sccr_pkg::sccr_status_t          status,
    input  logic                            in_action,
    input  logic [sccr_pkg::SECTOR_W-1:0]   in_sector,
    output logic                            out_hit,
    output logic [sccr_pkg::ENTRY_W-1:0]    out_entry,
    output logic                            out_fetch,
    output logic                            out_wb,
    output logic [sccr_pkg::SECTOR_W-1:0]   out_wb_sector
);

    // Index of the lowest set bit; zero when no bit is set.
    function automatic logic [sccr_pkg::IDX_W-1:0] first_set(
        input logic [sccr_pkg::ENTRIES-1:0] v
    );
        logic [sccr_pkg::IDX_W-1:0] idx;
        idx = '0;
        for (int i = sccr_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = sccr_pkg::IDX_W'(i);
            end
        end
        return idx;
    endfunction

    // Per-entry state bits and the clock hand.
    logic [sccr_pkg::ENTRIES-1:0]   valid_reg, valid_next;
    logic [sccr_pkg::ENTRIES-1:0]   dirty_reg, dirty_next;
    logic [sccr_pkg::ENTRIES-1:0]   ref_reg, ref_next;
    logic [sccr_pkg::IDX_W-1:0]     hand_reg, hand_next;

    // Transaction being worked on.
    logic                           action_reg, action_next;
    logic [sccr_pkg::SECTOR_W-1:0]  sector_reg, sector_next;
    logic [sccr_pkg::ENTRIES-1:0]   match_reg, match_next;
    logic [sccr_pkg::IDX_W-1:0]     slot_reg, slot_next;
    logic                           hit_reg, hit_next;
    logic                           evict_reg, evict_next;

    // Result register.
    logic                           out_hit_reg, out_hit_next;
    logic [sccr_pkg::ENTRY_W-1:0]   out_entry_reg, out_entry_next;
    logic                           out_fetch_reg, out_fetch_next;
    logic                           out_wb_reg, out_wb_next;
    logic [sccr_pkg::SECTOR_W-1:0]  out_wb_sector_reg, out_wb_sector_next;

    // Tag match array (every entry compared in place) and a memory copy of
    // the tags that is read at the clock hand for write-backs.
    logic [sccr_pkg::SECTOR_W-1:0]  cam_reg [sccr_pkg::ENTRIES];
    logic [sccr_pkg::SECTOR_W-1:0]  tag_mem [sccr_pkg::ENTRIES];
    logic [sccr_pkg::SECTOR_W-1:0]  rd_tag_reg;

    logic [sccr_pkg::IDX_W-1:0]     hand_inc;
    logic                           wb_dirty;

    assign hand_inc = (hand_reg == sccr_pkg::IDX_W'(sccr_pkg::ENTRIES - 1))
                    ? '0 : hand_reg + 1'b1;
    assign wb_dirty = evict_reg && dirty_reg[slot_reg];

    // Status toward the controller.
    assign status.hit_found   = |match_reg;
    assign status.free_found  = ~(&valid_reg);
    assign status.ref_at_hand = ref_reg[hand_reg];

    // Next-state logic for every command.
    always_comb
    begin
        valid_next         = valid_reg;
        dirty_next         = dirty_reg;
        ref_next           = ref_reg;
        hand_next          = hand_reg;
        action_next        = action_reg;
        sector_next        = sector_reg;
        match_next         = match_reg;
        slot_next          = slot_reg;
        hit_next           = hit_reg;
        evict_next         = evict_reg;
        out_hit_next       = out_hit_reg;
        out_entry_next     = out_entry_reg;
        out_fetch_next     = out_fetch_reg;
        out_wb_next        = out_wb_reg;
        out_wb_sector_next = out_wb_sector_reg;

        if (cmd.load)
        begin
            action_next = in_action;
            sector_next = in_sector;
        end

        // Only valid entries take part in the match.
        if (cmd.cmp)
        begin
            for (int i = 0; i < sccr_pkg::ENTRIES; i++)
            begin
                match_next[i] = valid_reg[i] && (cam_reg[i] == sector_reg);
            end
        end

        // A hit wins; otherwise the lowest free entry is taken.
        if (cmd.look)
        begin
            hit_next   = |match_reg;
            evict_next = 1'b0;
            slot_next  = (|match_reg) ? first_set(match_reg) : first_set(~valid_reg);
        end

        // Second chance: a set reference bit is cleared and the hand moves on;
        // a clear one makes the entry the victim. The hand always advances.
        if (cmd.scan_step)
        begin
            if (ref_reg[hand_reg])
            begin
                ref_next[hand_reg] = 1'b0;
            end
            else
            begin
                slot_next  = hand_reg;
                evict_next = 1'b1;
            end
            hand_next = hand_inc;
        end

        // Load the result and update the chosen entry.
        if (cmd.commit)
        begin
            out_hit_next       = hit_reg;
            out_entry_next     = sccr_pkg::ENTRY_W'(slot_reg);
            out_fetch_next     = ~hit_reg;
            out_wb_next        = wb_dirty;
            out_wb_sector_next = wb_dirty ? rd_tag_reg : '0;
            ref_next[slot_reg] = 1'b1;
            if (hit_reg)
            begin
                if (action_reg)
                begin
                    dirty_next[slot_reg] = 1'b1;
                end
            end
            else
            begin
                valid_next[slot_reg] = 1'b1;
                dirty_next[slot_reg] = action_reg;
            end
        end
    end

    // Entry state and clock hand.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            dirty_reg <= '0;
            ref_reg   <= '0;
            hand_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            ref_reg   <= ref_next;
            hand_reg  <= hand_next;
        end
    end

    // Working registers and result payload.
    always_ff @(posedge clk)
    begin
        action_reg        <= action_next;
        sector_reg        <= sector_next;
        match_reg         <= match_next;
        slot_reg          <= slot_next;
        hit_reg           <= hit_next;
        evict_reg         <= evict_next;
        out_hit_reg       <= out_hit_next;
        out_entry_reg     <= out_entry_next;
        out_fetch_reg     <= out_fetch_next;
        out_wb_reg        <= out_wb_next;
        out_wb_sector_reg <= out_wb_sector_next;
    end

    // Tags are written on every miss.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !hit_reg)
        begin
            cam_reg[slot_reg] <= sector_reg;
        end
    end

    // Tag memory: the last scan step reads the victim's old tag.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !hit_reg)
        begin
            tag_mem[slot_reg] <= sector_reg;
        end
        if (cmd.scan_step)
        begin
            rd_tag_reg <= tag_mem[hand_reg];
        end
    end

    assign out_hit       = out_hit_reg;
    assign out_entry     = out_entry_reg;
    assign out_fetch     = out_fetch_reg;
    assign out_wb        = out_wb_reg;
    assign out_wb_sector = out_wb_sector_reg;

endmodule

// ===== rtl/sccr_ctrl.sv =====
// ============================================================================
// sccr_ctrl
// Sequencer of the sector cache: steps one transaction through compare,
// selection, clock scan when full, and commit; owns both stream handshakes.
// ============================================================================
module sccr_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output sccr_pkg::sccr_cmd_t     cmd,
    input  sccr_pkg::sccr_status_t  status
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_LOOK = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    // The result register can take a new result when empty or being drained.
    assign out_free = ~out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    // State transitions and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = (status.hit_found || status.free_found) ? S_DONE : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (!status.ref_at_hand)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag.
    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/sector_cache_clock_replacement_unit.sv =====
// ============================================================================
// Sector cache clock replacement unit
// Tag and replacement controller of a fully associative disk-sector cache.
// Each transaction in is one read or write of a sector; each transaction out
// reports whether it hit, which entry now holds the sector, whether that
// sector must be fetched from disk and, on eviction of a dirty entry, which
// old sector must be written back. Misses take the lowest free entry, and
// once the cache is full a second-chance clock scan picks the victim.
// One transaction is handled at a time. A hit or a miss into a free entry
// steps through capture, the parallel tag compare, the pick of the entry
// and commit. The result register loads at the commit step, and the next
// transaction can be accepted in the cycle after that. An eviction adds a
// clock scan step for each entry the clock hand examines, from 1 up to
// ENTRIES + 1 (all reference bits set); the hand examines one entry per
// cycle. A new transaction is accepted while the previous result still
// waits in the output register; it then holds at the commit step until that
// result has been taken.
// ============================================================================
module sector_cache_clock_replacement_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sccr_pkg::S_TDATA_W-1:0]   s_tdata,   // sector[31:0]
    input  logic                             s_tuser,   // action (0 read, 1 write)
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // hit[0], entry[6:1], fetch_needed[7], writeback_needed[8],
    // writeback_sector[40:9], zero pad[47:41]
    output logic [sccr_pkg::M_TDATA_W-1:0]   m_tdata
);

    sccr_pkg::sccr_cmd_t              cmd;
    sccr_pkg::sccr_status_t           status;
    logic                             out_hit;
    logic [sccr_pkg::ENTRY_W-1:0]     out_entry;
    logic                             out_fetch;
    logic                             out_wb;
    logic [sccr_pkg::SECTOR_W-1:0]    out_wb_sector;

    sccr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    sccr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_action     (s_tuser),
        .in_sector     (s_tdata[sccr_pkg::SECTOR_W-1:0]),
        .out_hit       (out_hit),
        .out_entry     (out_entry),
        .out_fetch     (out_fetch),
        .out_wb        (out_wb),
        .out_wb_sector (out_wb_sector)
    );

    // Pack the result fields from bit 0 upward.
    assign m_tdata = {{(sccr_pkg::M_TDATA_W - sccr_pkg::OUT_BITS){1'b0}},
                      out_wb_sector, out_wb, out_fetch, out_entry, out_hit};

endmodule

// ===== rtl/sccr_checker.sv =====
// ============================================================================
// sccr_checker
// Port-level checks of the sector cache clock replacement unit, bound to
// the top level.
// ============================================================================
`include "sector_cache_clock_replacement_unit_defines.svh"

module sccr_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [sccr_pkg::M_TDATA_W-1:0]  m_tdata
);

    // A stalled result holds its value.
    `SCCR_ASSERT_NEXT(a_result_held, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "stalled result changed")

    // Only one transaction is in work: no acceptance right after one.
    `SCCR_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready,
        !s_tready, "input accepted while a transaction was in work")

    // Every result is either a hit or a fetch, never both, and a hit evicts
    // nothing.
    `SCCR_ASSERT_SAME(a_hit_or_fetch, clk, rst_n, m_tvalid,
        (m_tdata[0] != m_tdata[7]) && !(m_tdata[0] && m_tdata[8]),
        "hit and fetch flags inconsistent")

    // Without a write-back the reported sector is zero.
    `SCCR_ASSERT_SAME(a_wb_sector_zero, clk, rst_n, m_tvalid && !m_tdata[8],
        m_tdata[40:9] == 32'd0, "write-back sector set without write-back")

endmodule

bind sector_cache_clock_replacement_unit sccr_checker u_sccr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
